[rtl/core/bmrf_pkg.sv]
// Shared types, codes and helper functions of the banked mode register file.
// Used by bmrf_decode, bmrf_bank and banked_mode_register_file_top; no dependencies.
`default_nettype none

package bmrf_pkg;

	localparam int DATA_W      = 32;
	localparam int BANK_DEPTH  = 31;
	localparam int SLOT_W      = 5;
	localparam int SAVED_DEPTH = 5;
	localparam int SAVED_W     = 3;
	localparam int MODE_W      = 5;
	localparam int ARCH_W      = 4;

	localparam logic [ARCH_W-1:0] ARCH_RESET   = 4'd4;
	localparam logic [ARCH_W-1:0] ARCH_SYS_MIN = 4'd4;
	localparam logic [ARCH_W-1:0] ARCH_NV_MIN  = 4'd3;

	// Mode encodings
	localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
	localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
	localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
	localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
	localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
	localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
	localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

	// Bank slot bases
	localparam logic [SLOT_W-1:0] SLOT_FIQ_BASE = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_SVC_BASE = 5'd23;
	localparam logic [SLOT_W-1:0] SLOT_ABT_BASE = 5'd25;
	localparam logic [SLOT_W-1:0] SLOT_UND_BASE = 5'd27;
	localparam logic [SLOT_W-1:0] SLOT_IRQ_BASE = 5'd29;

	// Saved status slots
	localparam logic [SAVED_W-1:0] SAVED_FIQ = 3'd0;
	localparam logic [SAVED_W-1:0] SAVED_IRQ = 3'd1;
	localparam logic [SAVED_W-1:0] SAVED_SVC = 3'd2;
	localparam logic [SAVED_W-1:0] SAVED_ABT = 3'd3;
	localparam logic [SAVED_W-1:0] SAVED_UND = 3'd4;

	// Status field selectors
	localparam logic [3:0] FLD_WORD = 4'd0;
	localparam logic [3:0] FLD_MODE = 4'd1;
	localparam logic [3:0] FLD_T    = 4'd2;
	localparam logic [3:0] FLD_F    = 4'd3;
	localparam logic [3:0] FLD_I    = 4'd4;
	localparam logic [3:0] FLD_Q    = 4'd5;
	localparam logic [3:0] FLD_V    = 4'd6;
	localparam logic [3:0] FLD_C    = 4'd7;
	localparam logic [3:0] FLD_Z    = 4'd8;
	localparam logic [3:0] FLD_N    = 4'd9;

	// Flag bit positions in the status word
	localparam int BIT_N = 31;
	localparam int BIT_Z = 30;
	localparam int BIT_C = 29;
	localparam int BIT_V = 28;
	localparam int BIT_Q = 27;

	typedef enum logic [2:0] {
		KIND_RD_REG    = 3'd0,
		KIND_WR_REG    = 3'd1,
		KIND_RD_STATUS = 3'd2,
		KIND_WR_STATUS = 3'd3,
		KIND_RD_SAVED  = 3'd4,
		KIND_WR_SAVED  = 3'd5,
		KIND_COPY      = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_NO_SAVED  = 2'd1,
		ERR_BAD_MODE  = 2'd2,
		ERR_SYS_EARLY = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		MC_USR, MC_FIQ, MC_IRQ, MC_SVC, MC_ABT, MC_UND, MC_SYS, MC_BAD
	} mode_class_t;

	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		err_t              err;
	} slot_t;

	typedef struct packed {
		logic [SAVED_W-1:0] idx;
		err_t               err;
	} saved_sel_t;

	// Decoded access, handed from the decoder to the top level
	typedef struct packed {
		logic               rd_en;
		logic [SLOT_W-1:0]  rd_slot;
		logic               bank_we;
		logic [SLOT_W-1:0]  wr_slot;
		logic               copy;
		logic               use_bank;
		logic [DATA_W-1:0]  imm_data;
		err_t               err;
		logic               pass;
		logic [DATA_W-1:0]  status_nxt;
		logic               saved_we;
		logic [SAVED_W-1:0] saved_idx;
	} dec_t;

	function automatic mode_class_t mode_class(input logic [MODE_W-1:0] mode);
		mode_class_t mc;
		case (mode)
			MODE_USR: mc = MC_USR;
			MODE_FIQ: mc = MC_FIQ;
			MODE_IRQ: mc = MC_IRQ;
			MODE_SVC: mc = MC_SVC;
			MODE_ABT: mc = MC_ABT;
			MODE_UND: mc = MC_UND;
			MODE_SYS: mc = MC_SYS;
			default:  mc = MC_BAD;
		endcase
		return mc;
	endfunction

	function automatic err_t mode_error(input mode_class_t mc, input logic [ARCH_W-1:0] arch);
		err_t e;
		e = ERR_NONE;
		if (mc == MC_BAD)
			e = ERR_BAD_MODE;
		else if (mc == MC_SYS && arch < ARCH_SYS_MIN)
			e = ERR_SYS_EARLY;
		return e;
	endfunction

	// Register number to bank slot; R0..R7 and R15 are never banked
	function automatic slot_t reg_slot(input logic [3:0] r, input mode_class_t mc,
			input logic [ARCH_W-1:0] arch);
		slot_t s;
		logic [SLOT_W-1:0] off;
		off = {1'b0, 4'(r - 4'd13)};
		s.slot = {1'b0, r};
		s.err  = ERR_NONE;
		if (r[3] && r != 4'd15) begin
			s.err = mode_error(mc, arch);
			if (s.err != ERR_BAD_MODE) begin
				if (mc == MC_FIQ) begin
					s.slot = SLOT_FIQ_BASE + {2'b00, r[2:0]};
				end else if (r >= 4'd13) begin
					case (mc)
						MC_SVC:  s.slot = SLOT_SVC_BASE + off;
						MC_ABT:  s.slot = SLOT_ABT_BASE + off;
						MC_UND:  s.slot = SLOT_UND_BASE + off;
						MC_IRQ:  s.slot = SLOT_IRQ_BASE + off;
						default: s.slot = {1'b0, r};
					endcase
				end
			end
		end
		return s;
	endfunction

	function automatic saved_sel_t saved_slot(input mode_class_t mc,
			input logic [ARCH_W-1:0] arch);
		saved_sel_t s;
		s.idx = SAVED_FIQ;
		s.err = mode_error(mc, arch);
		if (s.err == ERR_NONE) begin
			case (mc)
				MC_FIQ:  s.idx = SAVED_FIQ;
				MC_IRQ:  s.idx = SAVED_IRQ;
				MC_SVC:  s.idx = SAVED_SVC;
				MC_ABT:  s.idx = SAVED_ABT;
				MC_UND:  s.idx = SAVED_UND;
				default: s.err = ERR_NO_SAVED;
			endcase
		end
		return s;
	endfunction

	// Bit position of a single-bit status field
	function automatic logic [4:0] field_pos(input logic [3:0] fld);
		logic [4:0] p;
		case (fld)
			FLD_T:   p = 5'd5;
			FLD_F:   p = 5'd6;
			FLD_I:   p = 5'd7;
			FLD_Q:   p = 5'(BIT_Q);
			FLD_V:   p = 5'(BIT_V);
			FLD_C:   p = 5'(BIT_C);
			FLD_Z:   p = 5'(BIT_Z);
			FLD_N:   p = 5'(BIT_N);
			default: p = 5'd0;
		endcase
		return p;
	endfunction

	function automatic logic cond_holds(input logic [3:0] c, input logic [DATA_W-1:0] sw,
			input logic [ARCH_W-1:0] arch);
		logic n, z, cy, v, h;
		n  = sw[BIT_N];
		z  = sw[BIT_Z];
		cy = sw[BIT_C];
		v  = sw[BIT_V];
		case (c)
			COND_EQ: h = z;
			COND_NE: h = !z;
			COND_CS: h = cy;
			COND_CC: h = !cy;
			COND_MI: h = n;
			COND_PL: h = !n;
			COND_VS: h = v;
			COND_VC: h = !v;
			COND_HI: h = cy && !z;
			COND_LS: h = !cy || z;
			COND_GE: h = (n == v);
			COND_LT: h = (n != v);
			COND_GT: h = !z && (n == v);
			COND_LE: h = z || (n != v);
			COND_AL: h = 1'b1;
			default: h = (arch >= ARCH_NV_MIN);
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

[rtl/core/banked_mode_register_file_top.sv]
// Top level of the banked mode register file: stream handshake, status word,
// saved status, access stage and output register. Uses bmrf_pkg, bmrf_decode, bmrf_bank.
`default_nettype none

// One access per input transfer, one result transfer per access. An access
// is accepted at an edge, where the bank memory registers its read; the
// result is registered from that read data in the cycle after, and copies
// write their destination there too. No next access is accepted before that
// result edge, so the block holds one access in flight at a time, as the
// registered read of the bank memory lies ahead of its single write port. A pending result
// that is not taken holds off further accesses. Register writes, status and
// saved status updates take effect at the accept edge; arch_level (cfg_wr_data)
// is written whenever cfg_wr_en is high and resets to 4.
module banked_mode_register_file_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: arch_level
	input  wire logic        cfg_wr_en,
	input  wire logic [3:0]  cfg_wr_data,
	// access stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // reg_index, src_index, status_field, write_data, cond_code
	input  wire logic [2:0]  s_axis_tuser,  // kind
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // read_data, current_mode, zero fill
	output logic [2:0]       m_axis_tuser   // cond_pass, error_code
);

	logic                                                 accept;
	logic [bmrf_pkg::ARCH_W-1:0]                          arch_q;
	logic [bmrf_pkg::DATA_W-1:0]                          status_q;
	logic [bmrf_pkg::SAVED_DEPTH-1:0][bmrf_pkg::DATA_W-1:0] saved_q;
	bmrf_pkg::dec_t                                       dec;

	logic                          busy_s1;
	logic                          use_bank_s1;
	logic                          copy_s1;
	logic [bmrf_pkg::SLOT_W-1:0]   wr_slot_s1;
	logic [bmrf_pkg::DATA_W-1:0]   imm_s1;
	bmrf_pkg::err_t                err_s1;
	logic                          pass_s1;
	logic [bmrf_pkg::MODE_W-1:0]   mode_s1;

	logic                          bank_we;
	logic [bmrf_pkg::SLOT_W-1:0]   bank_waddr;
	logic [bmrf_pkg::DATA_W-1:0]   bank_wdata;
	logic [bmrf_pkg::DATA_W-1:0]   bank_rdata;

	logic                          out_valid_q;
	logic [bmrf_pkg::DATA_W-1:0]   out_data_q;
	logic [bmrf_pkg::MODE_W-1:0]   out_mode_q;
	logic                          out_pass_q;
	bmrf_pkg::err_t                out_err_q;

	// Handshake: one access in flight, output slot free by the result edge
	assign s_axis_tready = !busy_s1 && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	bmrf_decode u_decode (
		.kind         (s_axis_tuser),
		.reg_index    (s_axis_tdata[3:0]),
		.src_index    (s_axis_tdata[7:4]),
		.status_field (s_axis_tdata[11:8]),
		.write_data   (s_axis_tdata[43:12]),
		.cond_code    (s_axis_tdata[47:44]),
		.status_q     (status_q),
		.saved_q      (saved_q),
		.arch_level   (arch_q),
		.dec          (dec)
	);

	// Bank write port: register writes at accept, copies in the following cycle
	always_comb begin
		if (busy_s1) begin
			bank_we    = copy_s1;
			bank_waddr = wr_slot_s1;
			bank_wdata = bank_rdata;
		end else begin
			bank_we    = accept && dec.bank_we;
			bank_waddr = dec.wr_slot;
			bank_wdata = s_axis_tdata[43:12];
		end
	end

	bmrf_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && dec.rd_en),
		.rd_addr (dec.rd_slot),
		.rd_data (bank_rdata),
		.wr_en   (bank_we),
		.wr_addr (bank_waddr),
		.wr_data (bank_wdata)
	);

	// Configuration, status word and saved status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q   <= bmrf_pkg::ARCH_RESET;
			status_q <= '0;
			saved_q  <= '0;
		end else begin
			if (cfg_wr_en)
				arch_q <= cfg_wr_data;
			if (accept) begin
				status_q <= dec.status_nxt;
				if (dec.saved_we)
					saved_q[dec.saved_idx] <= s_axis_tdata[43:12];
			end
		end
	end

	// Access stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	// Access stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			use_bank_s1 <= dec.use_bank;
			copy_s1     <= dec.copy;
			wr_slot_s1  <= dec.wr_slot;
			imm_s1      <= dec.imm_data;
			err_s1      <= dec.err;
			pass_s1     <= dec.pass;
			mode_s1     <= dec.status_nxt[bmrf_pkg::MODE_W-1:0];
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (busy_s1) begin
			out_data_q <= use_bank_s1 ? bank_rdata : imm_s1;
			out_mode_q <= mode_s1;
			out_pass_q <= pass_s1;
			out_err_q  <= err_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_mode_q, out_data_q};
	assign m_axis_tuser  = {out_err_q, out_pass_q};

	// The result slot is always free when an access reaches its result edge
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !out_valid_q)
		else $error("result register occupied while an access completes");

	// An accepted access always produces a result after its access stage
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 out_valid_q)
		else $error("accepted access produced no result");

	// A waiting result reports the mode the status word currently holds
	a_mode_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (m_axis_tdata[36:32] == status_q[bmrf_pkg::MODE_W-1:0]))
		else $error("reported mode differs from status word");

	// A copy that writes never carries an invalid mode report
	a_copy_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && copy_s1) |-> (err_s1 != bmrf_pkg::ERR_BAD_MODE))
		else $error("copy written despite invalid mode");

endmodule

`default_nettype wire

[rtl/core/bmrf_bank.sv]
// Banked general register storage: 31 x 32 synchronous memory, registered read.
// Per-entry valid flops make unwritten entries read as zero. Uses bmrf_pkg.
`default_nettype none

module bmrf_bank (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [bmrf_pkg::SLOT_W-1:0]   rd_addr,
	output logic      [bmrf_pkg::DATA_W-1:0]   rd_data,
	input  wire logic                          wr_en,
	input  wire logic [bmrf_pkg::SLOT_W-1:0]   wr_addr,
	input  wire logic [bmrf_pkg::DATA_W-1:0]   wr_data
);

	logic [bmrf_pkg::DATA_W-1:0]     mem [bmrf_pkg::BANK_DEPTH];
	logic [bmrf_pkg::BANK_DEPTH-1:0] valid_q;
	logic [bmrf_pkg::DATA_W-1:0]     rdata_q;
	logic                            rvalid_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// Written-entry tracking, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rvalid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[rtl/core/bmrf_decode.sv]
// Access decoder: bank slot mapping, mode checks, condition check and the
// status / saved status updates of one access. Uses bmrf_pkg.
`default_nettype none

module bmrf_decode (
	input  wire logic [2:0]                                      kind,
	input  wire logic [3:0]                                      reg_index,
	input  wire logic [3:0]                                      src_index,
	input  wire logic [3:0]                                      status_field,
	input  wire logic [bmrf_pkg::DATA_W-1:0]                     write_data,
	input  wire logic [3:0]                                      cond_code,
	input  wire logic [bmrf_pkg::DATA_W-1:0]                     status_q,
	input  wire logic [bmrf_pkg::SAVED_DEPTH-1:0][bmrf_pkg::DATA_W-1:0] saved_q,
	input  wire logic [bmrf_pkg::ARCH_W-1:0]                     arch_level,
	output bmrf_pkg::dec_t                                       dec
);

	bmrf_pkg::mode_class_t mc;
	bmrf_pkg::slot_t       sd;
	bmrf_pkg::slot_t       ss;
	bmrf_pkg::saved_sel_t  sv;
	logic [4:0]            pos;

	always_comb begin
		mc  = bmrf_pkg::mode_class(status_q[bmrf_pkg::MODE_W-1:0]);
		sd  = bmrf_pkg::reg_slot(reg_index, mc, arch_level);
		ss  = bmrf_pkg::reg_slot(src_index, mc, arch_level);
		sv  = bmrf_pkg::saved_slot(mc, arch_level);
		pos = bmrf_pkg::field_pos(status_field);

		dec            = '0;
		dec.err        = bmrf_pkg::ERR_NONE;
		dec.pass       = bmrf_pkg::cond_holds(cond_code, status_q, arch_level);
		dec.status_nxt = status_q;
		dec.saved_idx  = sv.idx;

		case (bmrf_pkg::kind_t'(kind))
			bmrf_pkg::KIND_RD_REG: begin
				dec.err      = sd.err;
				dec.rd_slot  = sd.slot;
				dec.rd_en    = (sd.err != bmrf_pkg::ERR_BAD_MODE);
				dec.use_bank = (sd.err != bmrf_pkg::ERR_BAD_MODE);
			end
			bmrf_pkg::KIND_WR_REG: begin
				dec.err     = sd.err;
				dec.wr_slot = sd.slot;
				dec.bank_we = (sd.err != bmrf_pkg::ERR_BAD_MODE);
			end
			bmrf_pkg::KIND_RD_STATUS: begin
				if (status_field == bmrf_pkg::FLD_WORD)
					dec.imm_data = status_q;
				else if (status_field == bmrf_pkg::FLD_MODE)
					dec.imm_data = {27'd0, status_q[bmrf_pkg::MODE_W-1:0]};
				else if (status_field inside {[bmrf_pkg::FLD_T:bmrf_pkg::FLD_N]})
					dec.imm_data = {31'd0, status_q[pos]};
			end
			bmrf_pkg::KIND_WR_STATUS: begin
				if (status_field == bmrf_pkg::FLD_WORD)
					dec.status_nxt = write_data;
				else if (status_field == bmrf_pkg::FLD_MODE)
					dec.status_nxt[bmrf_pkg::MODE_W-1:0] = write_data[bmrf_pkg::MODE_W-1:0];
				else if (status_field inside {[bmrf_pkg::FLD_T:bmrf_pkg::FLD_N]})
					dec.status_nxt[pos] = write_data[0];
			end
			bmrf_pkg::KIND_RD_SAVED: begin
				dec.err = sv.err;
				if (sv.err == bmrf_pkg::ERR_NONE)
					dec.imm_data = saved_q[sv.idx];
			end
			bmrf_pkg::KIND_WR_SAVED: begin
				dec.err      = sv.err;
				dec.saved_we = (sv.err == bmrf_pkg::ERR_NONE);
			end
			bmrf_pkg::KIND_COPY: begin
				// source error takes precedence over destination error
				dec.err     = (ss.err != bmrf_pkg::ERR_NONE) ? ss.err : sd.err;
				dec.rd_slot = ss.slot;
				dec.wr_slot = sd.slot;
				dec.copy    = (dec.err != bmrf_pkg::ERR_BAD_MODE);
				dec.rd_en   = (dec.err != bmrf_pkg::ERR_BAD_MODE);
			end
			default: begin
				// unused kind: no operation
			end
		endcase
	end

endmodule

`default_nettype wire
